/* hdl/energy_bin_classifier_assert.svh */
// Assertion macros for the energy bin classifier.
// Included by the top level; macros collapse to nothing when SYNTHESIS is defined.
`ifndef ENERGY_BIN_CLASSIFIER_ASSERT_SVH
`define ENERGY_BIN_CLASSIFIER_ASSERT_SVH
`ifndef SYNTHESIS
`define EBC_ASSERT_SAME(lbl, ck, rst_n, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("energy_bin_classifier: same-cycle check failed");
`define EBC_ASSERT_NEXT(lbl, ck, rst_n, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("energy_bin_classifier: next-cycle check failed");
`else
`define EBC_ASSERT_SAME(lbl, ck, rst_n, ante, cons)
`define EBC_ASSERT_NEXT(lbl, ck, rst_n, ante, cons)
`endif
`endif

/* hdl/ebc_pkg.sv */
// Shared types and constants for the energy bin classifier.
// No dependencies; imported by ebc_regs, ebc_cell and energy_bin_classifier.
`default_nettype none

package ebc_pkg;

	localparam int unsigned DEFAULT_MAX_EDGES = 256;
	localparam int unsigned ADDR_W            = 4;
	localparam int unsigned DATA_W            = 32;
	localparam int unsigned VAL_W             = 63;
	localparam logic [8:0]  MAX_GROUPS        = 9'd256;

	localparam logic [8:0]  RST_EDGE_COUNT    = 9'd2;
	localparam logic        RST_SC_EN         = 1'b0;
	localparam logic [8:0]  RST_NUM_GROUPS    = 9'd1;
	localparam logic        RST_OUT_MODE      = 1'b0;
	localparam logic [8:0]  MIN_EDGE_COUNT    = 9'd2;

	typedef enum logic {
		OP_LOAD     = 1'b0,
		OP_CLASSIFY = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		REG_EDGE_COUNT = 2'd0,
		REG_SC_EN      = 2'd1,
		REG_NUM_GROUPS = 2'd2,
		REG_OUT_MODE   = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [8:0] edge_count;
		logic       sc_en;
		logic [8:0] num_groups;
		logic       out_mode;
	} cfg_t;

	// Transaction travelling down the cell row
	typedef struct packed {
		op_t              op;
		logic [7:0]       idx;
		logic [VAL_W-1:0] value;
		logic             ge_first;
		logic             le_last;
		logic             err;
		logic             sc;
		logic             sc_hit;
		logic [7:0]       sc_bin;
	} item_t;

	// Counter width: holds the edge count itself and at least a 9-bit register value
	function automatic int unsigned cnt_width(int unsigned max_edges);
		int unsigned nw;
		nw = $clog2(max_edges + 1);
		return (nw > 9) ? nw : 9;
	endfunction

endpackage

`default_nettype wire

/* hdl/ebc_regs.sv */
// APB-style configuration registers of the energy bin classifier.
// Depends on ebc_pkg for the register map and cfg_t.
`default_nettype none

module ebc_regs import ebc_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0] pwdata,
	output logic      [DATA_W-1:0] prdata,
	output logic                   pready,
	output cfg_t                   cfg
);

	cfg_t     cfg_q;
	reg_idx_t ridx;
	logic     wr;

	assign ridx   = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.edge_count <= RST_EDGE_COUNT;
			cfg_q.sc_en      <= RST_SC_EN;
			cfg_q.num_groups <= RST_NUM_GROUPS;
			cfg_q.out_mode   <= RST_OUT_MODE;
		end else if (wr) begin
			case (ridx)
				REG_EDGE_COUNT: cfg_q.edge_count <= pwdata[8:0];
				REG_SC_EN:      cfg_q.sc_en      <= pwdata[0];
				REG_NUM_GROUPS: cfg_q.num_groups <= pwdata[8:0];
				REG_OUT_MODE:   cfg_q.out_mode   <= pwdata[0];
				default:        cfg_q            <= cfg_q;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (ridx)
			REG_EDGE_COUNT: prdata = DATA_W'(cfg_q.edge_count);
			REG_SC_EN:      prdata = DATA_W'(cfg_q.sc_en);
			REG_NUM_GROUPS: prdata = DATA_W'(cfg_q.num_groups);
			REG_OUT_MODE:   prdata = DATA_W'(cfg_q.out_mode);
			default:        prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

/* hdl/ebc_cell.sv */
// One cell of the edge row: holds one bin edge, compares the passing transaction
// against it and hands the transaction to the next cell. Depends on ebc_pkg.
`default_nettype none

module ebc_cell import ebc_pkg::*; #(
	parameter int unsigned MAX_EDGES = DEFAULT_MAX_EDGES,
	parameter int unsigned IDX       = 0
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              adv,
	input  wire logic [cnt_width(MAX_EDGES)-1:0]   used,
	input  wire logic                              vld_i,
	input  wire item_t                             item_i,
	input  wire logic [cnt_width(MAX_EDGES)-1:0]   cnt_i,
	output logic                                   vld_o,
	output item_t                                  item_o,
	output logic [cnt_width(MAX_EDGES)-1:0]        cnt_o
);

	localparam int unsigned CW        = cnt_width(MAX_EDGES);
	localparam bit          CHECK_ERR = (IDX + 1 < MAX_EDGES);
	localparam logic [CW-1:0] POS      = CW'(IDX);
	localparam logic [CW-1:0] NEXT_POS = CW'(IDX + 1);

	logic             vld_q;
	item_t            item_q;
	logic [CW-1:0]    cnt_q;
	logic [VAL_W-1:0] edge_q;

	item_t         nxt;
	logic [CW-1:0] cnt_nxt;
	logic [CW-1:0] idx_ext;
	logic          is_ld;
	logic          is_cls;
	logic          wr_edge;

	assign idx_ext = CW'(item_i.idx);
	assign is_ld   = (item_i.op == OP_LOAD);
	assign is_cls  = (item_i.op == OP_CLASSIFY);
	assign wr_edge = adv && vld_i && is_ld && (idx_ext == POS);

	always_comb begin
		nxt     = item_i;
		cnt_nxt = cnt_i;
		if (is_cls && (POS < used) && (edge_q < item_i.value)) begin
			cnt_nxt = cnt_i + CW'(1);
		end
		if (is_cls && (POS == '0) && (item_i.value >= edge_q)) begin
			nxt.ge_first = 1'b1;
		end
		if (is_cls && (POS == used - CW'(1)) && (item_i.value <= edge_q)) begin
			nxt.le_last = 1'b1;
		end
		// flag a load whose edge does not sit above this one
		if (CHECK_ERR && is_ld && (idx_ext == NEXT_POS) && (item_i.value <= edge_q)) begin
			nxt.err = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (adv) begin
			vld_q <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			item_q <= nxt;
			cnt_q  <= cnt_nxt;
		end
		if (wr_edge) begin
			edge_q <= item_i.value;
		end
	end

	assign vld_o  = vld_q;
	assign item_o = item_q;
	assign cnt_o  = cnt_q;

endmodule

`default_nettype wire

/* hdl/energy_bin_classifier.sv */
// Channel   Handshake            Payload
// req       req_valid/req_stall  op, edge_index, boundary_value, energy, group_valid,
//                                group, last_group, tracklength
// rsp       rsp_valid/rsp_stall  bin, hit, load_error
// cfg       APB psel/penable     paddr, pwdata, prdata, pready
//
// One transaction per cycle while no result is held; a transaction passes through the register
// of each edge cell of the row and then through the result register.
// A held result freezes the whole row; one more transaction waits in the input skid.
// Reset clears the valid bits and restores the register defaults; edges are undefined until loaded (no clearing pass).
// Top level: ebc_regs, a row of ebc_cell; depends on ebc_pkg and the assertion header.
`default_nettype none
`include "energy_bin_classifier_assert.svh"

module energy_bin_classifier import ebc_pkg::*; #(
	parameter int unsigned MAX_EDGES = DEFAULT_MAX_EDGES
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0] pwdata,
	output logic      [DATA_W-1:0] prdata,
	output logic                   pready,
	input  wire logic              req_valid,
	output logic                   req_stall,
	input  wire logic              op,
	input  wire logic [7:0]        edge_index,
	input  wire logic [VAL_W-1:0]  boundary_value,
	input  wire logic [VAL_W-1:0]  energy,
	input  wire logic              group_valid,
	input  wire logic [7:0]        group,
	input  wire logic [7:0]        last_group,
	input  wire logic              tracklength,
	output logic                   rsp_valid,
	input  wire logic              rsp_stall,
	output logic      [7:0]        bin,
	output logic                   hit,
	output logic                   load_error
);

	localparam int unsigned CW = cnt_width(MAX_EDGES);

	cfg_t          cfg;
	logic [CW-1:0] used;
	logic [8:0]    ec_min;
	logic          adv;

	logic          skid_valid_q;
	item_t         skid_q;
	item_t         new_item;
	logic [8:0]    ng;
	logic [8:0]    gsel;

	logic          vld  [0:MAX_EDGES];
	item_t         item [0:MAX_EDGES];
	logic [CW-1:0] cnt  [0:MAX_EDGES];

	logic          rsp_valid_q;
	logic [7:0]    bin_q;
	logic          hit_q;
	logic          load_error_q;
	logic [7:0]    r_bin;
	logic          r_hit;
	logic          r_err;
	logic [CW-1:0] cnt_m1;
	item_t         fin;

	ebc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Clamp the edge count to [2, MAX_EDGES]
	assign ec_min = (cfg.edge_count < MIN_EDGE_COUNT) ? MIN_EDGE_COUNT : cfg.edge_count;
	assign used   = (CW'(ec_min) > CW'(MAX_EDGES)) ? CW'(MAX_EDGES) : CW'(ec_min);

	assign adv       = !rsp_valid_q || !rsp_stall;
	assign req_stall = skid_valid_q;

	// Group shortcut is resolved on entry; the row only passes it along
	always_comb begin
		ng   = (cfg.num_groups > MAX_GROUPS) ? MAX_GROUPS : cfg.num_groups;
		gsel = (cfg.out_mode || tracklength) ? {1'b0, group} : {1'b0, last_group};
		new_item          = '0;
		new_item.op       = op_t'(op);
		new_item.idx      = edge_index;
		new_item.value    = (op_t'(op) == OP_LOAD) ? boundary_value : energy;
		new_item.sc       = (op_t'(op) == OP_CLASSIFY) && cfg.sc_en && group_valid;
		new_item.sc_hit   = gsel < ng;
		new_item.sc_bin   = 8'(ng - gsel - 9'd1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_valid_q <= 1'b0;
		end else if (adv) begin
			skid_valid_q <= 1'b0;
		end else if (req_valid && !skid_valid_q) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!adv && req_valid && !skid_valid_q) begin
			skid_q <= new_item;
		end
	end

	assign vld[0]  = skid_valid_q || req_valid;
	assign item[0] = skid_valid_q ? skid_q : new_item;
	assign cnt[0]  = '0;

	for (genvar i = 0; i < MAX_EDGES; i++) begin : g_cell
		ebc_cell #(
			.MAX_EDGES (MAX_EDGES),
			.IDX       (i)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.adv    (adv),
			.used   (used),
			.vld_i  (vld[i]),
			.item_i (item[i]),
			.cnt_i  (cnt[i]),
			.vld_o  (vld[i+1]),
			.item_o (item[i+1]),
			.cnt_o  (cnt[i+1])
		);
	end

	assign fin    = item[MAX_EDGES];
	assign cnt_m1 = cnt[MAX_EDGES] - CW'(1);

	always_comb begin
		r_bin = '0;
		r_hit = 1'b0;
		r_err = 1'b0;
		if (fin.op == OP_LOAD) begin
			r_err = fin.err;
		end else if (fin.sc) begin
			r_hit = fin.sc_hit;
			r_bin = fin.sc_hit ? fin.sc_bin : '0;
		end else if (fin.ge_first && fin.le_last) begin
			r_hit = 1'b1;
			r_bin = (cnt[MAX_EDGES] == '0) ? '0 : cnt_m1[7:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (adv) begin
			rsp_valid_q <= vld[MAX_EDGES];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			bin_q        <= r_bin;
			hit_q        <= r_hit;
			load_error_q <= r_err;
		end
	end

	assign rsp_valid  = rsp_valid_q;
	assign bin        = bin_q;
	assign hit        = hit_q;
	assign load_error = load_error_q;

	`EBC_ASSERT_SAME(a_load_no_hit, clk, arst_n, rsp_valid_q && load_error_q, !hit_q && (bin_q == '0))
	`EBC_ASSERT_NEXT(a_skid_hold, clk, arst_n, skid_valid_q && !adv, skid_valid_q)
	`EBC_ASSERT_NEXT(a_skid_fill, clk, arst_n, req_valid && !skid_valid_q && !adv, skid_valid_q)
	`EBC_ASSERT_NEXT(a_skid_drain, clk, arst_n, skid_valid_q && adv, !skid_valid_q)
	`EBC_ASSERT_NEXT(a_row_freeze, clk, arst_n, !adv, $stable(vld[1]) && rsp_valid_q)

endmodule

`default_nettype wire

/* tb/sv/tb_top.sv */
// Self-checking bench for energy_bin_classifier: edge loads and energy/group classification.
// A directed table runs first, then random phases with fresh register settings and idling.
// Depends on ebc_pkg and the energy_bin_classifier RTL only.
`default_nettype none

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import ebc_pkg::*;

	localparam int unsigned PIPE_DEPTH   = DEFAULT_MAX_EDGES + 1;
	localparam int unsigned QUIET_LIMIT  = 16 * PIPE_DEPTH;
	localparam int unsigned ITEM_TARGET  = 1850;
	localparam logic [63:0] TOP63        = 64'h7FFF_FFFF_FFFF_FFFF;

	typedef struct packed {
		op_t        op;
		logic [7:0] idx;
		logic [62:0] bval;
		logic [62:0] nrg;
		logic       gv;
		logic [7:0] grp;
		logic [7:0] lgrp;
		logic       trk;
	} req_t;

	typedef struct packed {
		logic [7:0] bin;
		logic       hit;
		logic       lerr;
	} bin_result_t;

	typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;

	typedef struct {
		row_kind_t   kind;
		reg_idx_t    reg_sel;
		int unsigned reg_val;
		req_t        req;
		bit          typed;
		bin_result_t want;
	} row_t;

	logic                clk;
	logic                arst_n         = 1'b0;
	logic                psel           = 1'b0;
	logic                penable        = 1'b0;
	logic                pwrite         = 1'b0;
	logic [ADDR_W-1:0]   paddr          = '0;
	logic [DATA_W-1:0]   pwdata         = '0;
	logic [DATA_W-1:0]   prdata;
	logic                pready;
	logic                req_valid      = 1'b0;
	logic                req_stall;
	logic                op             = 1'b0;
	logic [7:0]          edge_index     = '0;
	logic [VAL_W-1:0]    boundary_value = '0;
	logic [VAL_W-1:0]    energy         = '0;
	logic                group_valid    = 1'b0;
	logic [7:0]          group          = '0;
	logic [7:0]          last_group     = '0;
	logic                tracklength    = 1'b0;
	logic                rsp_valid;
	logic                rsp_stall      = 1'b0;
	logic [7:0]          bin;
	logic                hit;
	logic                load_error;

	// Predictor state: the edge table, the written prefix and a copy of the registers
	logic [62:0]   edge_tab [DEFAULT_MAX_EDGES];
	int unsigned   filled = 0;
	logic [8:0]    cfg_edge_count = RST_EDGE_COUNT;
	logic          cfg_sc         = RST_SC_EN;
	logic [8:0]    cfg_ng         = RST_NUM_GROUPS;
	logic          cfg_om         = RST_OUT_MODE;

	bin_result_t   pending_bins [$];
	bin_result_t   head;
	row_t          plan [$];
	int unsigned   fails = 0;
	int unsigned   sent  = 0;
	int unsigned   quiet = 0;
	bit            no_idle = 1'b0;

	energy_bin_classifier dut (.*);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic logic [63:0] rnd64();
		return {$urandom, $urandom};
	endfunction

	// Random magnitude: spread values over every exponent range
	function automatic logic [62:0] rnd_mag();
		logic [63:0] x;
		x = rnd64();
		return x[62:0] >> $urandom_range(62);
	endfunction

	function automatic req_t rand_payload();
		req_t r;
		r.op   = OP_CLASSIFY;
		r.idx  = 8'($urandom);
		r.bval = 63'(rnd64());
		r.nrg  = 63'(rnd64());
		r.gv   = 1'($urandom);
		r.grp  = 8'($urandom);
		r.lgrp = 8'($urandom);
		r.trk  = 1'($urandom);
		return r;
	endfunction

	function automatic int unsigned edges_in_use();
		if (cfg_edge_count < MIN_EDGE_COUNT) return 2;
		if (cfg_edge_count > DEFAULT_MAX_EDGES) return DEFAULT_MAX_EDGES;
		return cfg_edge_count;
	endfunction

	function automatic int unsigned groups_in_use();
		return (cfg_ng > MAX_GROUPS) ? 256 : cfg_ng;
	endfunction

	// Result of one transaction; a load also updates the edge table
	function automatic bin_result_t bin_lookup(input req_t r);
		bin_result_t res;
		int unsigned n, below, ng, g, i;
		res = '0;
		if (r.op == OP_LOAD) begin
			if (r.idx != 8'd0 && r.bval <= edge_tab[r.idx - 8'd1]) res.lerr = 1'b1;
			edge_tab[r.idx] = r.bval;
			if (r.idx == filled) filled++;
		end else if (cfg_sc && r.gv) begin
			ng = groups_in_use();
			g  = (cfg_om || r.trk) ? r.grp : r.lgrp;
			if (g < ng) begin
				res.bin = 8'(ng - g - 1);
				res.hit = 1'b1;
			end
		end else begin
			n = edges_in_use();
			if (r.nrg >= edge_tab[0] && r.nrg <= edge_tab[n - 1]) begin
				below = 0;
				for (i = 0; i < n; i++)
					if (edge_tab[i] < r.nrg) below++;
				res.bin = (below > 0) ? 8'(below - 1) : 8'd0;
				res.hit = 1'b1;
			end
		end
		return res;
	endfunction

	function automatic row_t row_load(input int unsigned idx, input logic [62:0] val,
			input bit err);
		row_t w;
		w.kind      = ROW_ITEM;
		w.reg_sel   = REG_EDGE_COUNT;
		w.reg_val   = 0;
		w.req       = '0;
		w.req.op    = OP_LOAD;
		w.req.idx   = 8'(idx);
		w.req.bval  = val;
		w.typed     = 1'b1;
		w.want      = '0;
		w.want.lerr = err;
		return w;
	endfunction

	function automatic row_t row_bin(input logic [62:0] e, input bit gv, input int unsigned g,
			input int unsigned lg, input bit trk, input bit typed, input int unsigned wbin,
			input bit whit);
		row_t w;
		w.kind     = ROW_ITEM;
		w.reg_sel  = REG_EDGE_COUNT;
		w.reg_val  = 0;
		w.req      = '0;
		w.req.op   = OP_CLASSIFY;
		w.req.nrg  = e;
		w.req.gv   = gv;
		w.req.grp  = 8'(g);
		w.req.lgrp = 8'(lg);
		w.req.trk  = trk;
		w.typed    = typed;
		w.want     = '0;
		w.want.bin = 8'(wbin);
		w.want.hit = whit;
		return w;
	endfunction

	function automatic row_t row_reg(input reg_idx_t ri, input int unsigned v);
		row_t w;
		w.kind    = ROW_REG;
		w.reg_sel = ri;
		w.reg_val = v;
		w.req     = '0;
		w.typed   = 1'b0;
		w.want    = '0;
		return w;
	endfunction

	// Append one row to the end of the directed table
	function automatic void add_row(input row_t w);
		plan.insert(plan.size(), w);
	endfunction

	task automatic send_req(input req_t r, input bit typed, input bin_result_t want);
		bin_result_t guess;
		if (!no_idle && $urandom_range(99) < 28) begin
			req_valid <= 1'b0;
			do begin
				@(posedge clk);
			end while (!no_idle && $urandom_range(99) < 28);
		end
		req_valid      <= 1'b1;
		op             <= r.op;
		edge_index     <= r.idx;
		boundary_value <= r.bval;
		energy         <= r.nrg;
		group_valid    <= r.gv;
		group          <= r.grp;
		last_group     <= r.lgrp;
		tracklength    <= r.trk;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		guess = bin_lookup(r);
		pending_bins.insert(pending_bins.size(), typed ? want : guess);
		sent++;
	endtask

	task automatic drain_bins();
		req_valid <= 1'b0;
		while (pending_bins.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t ri, input int unsigned v);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_W'({ri, 2'b00});
		pwdata  <= DATA_W'(v);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		case (ri)
			REG_EDGE_COUNT: cfg_edge_count = 9'(v);
			REG_SC_EN:      cfg_sc         = 1'(v);
			REG_NUM_GROUPS: cfg_ng         = 9'(v);
			REG_OUT_MODE:   cfg_om         = 1'(v);
			default: ;
		endcase
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	// Load m ascending edges from position 0, now and then repeating the previous one
	task automatic refill_edges(input int unsigned m);
		req_t r;
		logic [63:0] lo, span, sm, cur;
		int unsigned k;
		lo   = 64'(rnd_mag());
		span = (TOP63 - lo) / (m + 1);
		if (span == 0) begin
			lo   = TOP63 - 64'd4096;
			span = 64'd4096 / (m + 1);
		end
		cur = lo;
		for (k = 0; k < m; k++) begin
			sm = span >> $urandom_range(50);
			if (sm == 0) sm = 64'd1;
			cur    = cur + 64'd1 + rnd64() % sm;
			r      = rand_payload();
			r.op   = OP_LOAD;
			r.idx  = 8'(k);
			r.bval = cur[62:0];
			if (k > 0 && $urandom_range(39) == 0) r.bval = edge_tab[k - 1];
			send_req(r, 1'b0, '0);
		end
	endtask

	task automatic drive_mix_item();
		req_t r;
		int unsigned n, k, ng;
		logic [63:0] lo, hi, e;
		r = rand_payload();
		if ($urandom_range(99) < 12) begin
			// keep the written part of the table a prefix
			r.op  = OP_LOAD;
			r.idx = 8'($urandom_range(filled > 255 ? 255 : filled));
			if (r.idx != 8'd0 && $urandom_range(1))
				r.bval = edge_tab[r.idx - 8'd1] + 63'($urandom_range(2));
			else
				r.bval = rnd_mag();
		end else begin
			r.op = OP_CLASSIFY;
			ng   = groups_in_use();
			if (ng > 0 && $urandom_range(9) < 7) begin
				r.grp  = 8'($urandom_range(ng - 1));
				r.lgrp = 8'($urandom_range(ng - 1));
			end
			n  = edges_in_use();
			lo = 64'(edge_tab[0]);
			hi = 64'(edge_tab[n - 1]);
			k  = $urandom_range(n - 1);
			case ($urandom_range(9))
				0, 1, 2: e = 64'(edge_tab[k]);
				3:       e = 64'(edge_tab[k]) + 64'd1;
				4:       e = 64'(edge_tab[k]) - 64'd1;
				5, 6, 7: e = (hi >= lo) ? lo + rnd64() % (hi - lo + 64'd1) : rnd64();
				default: e = 64'(rnd_mag());
			endcase
			r.nrg = e[62:0];
		end
		send_req(r, 1'b0, '0);
	endtask

	always @(posedge clk) begin
		rsp_stall <= !no_idle && ($urandom_range(99) < 28);
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_bins.size() == 0) begin
				$error("result with no transaction outstanding: bin %0d hit %0d load_error %0d",
					bin, hit, load_error);
				fails++;
			end else begin
				head = pending_bins.pop_front();
				if (bin !== head.bin) begin
					$error("bin: expected %0d, got %0d", head.bin, bin);
					fails++;
				end
				if (hit !== head.hit) begin
					$error("hit: expected %0d, got %0d", head.hit, hit);
					fails++;
				end
				if (load_error !== head.lerr) begin
					$error("load_error: expected %0d, got %0d", head.lerr, load_error);
					fails++;
				end
			end
		end
	end

	// End the run when neither channel has moved for too long
	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= QUIET_LIMIT) begin
			$display("tb_top failed");
			$finish;
		end
	end

	initial begin
		int unsigned phase, ec, ngv, n;
		add_row(row_load(0, 63'd0, 1'b0));
		add_row(row_load(1, TOP63[62:0], 1'b0));
		add_row(row_bin(63'd0, 1'b0, 0, 0, 1'b0, 1'b1, 0, 1'b1));
		add_row(row_bin(TOP63[62:0], 1'b1, 255, 255, 1'b1, 1'b1, 0, 1'b1));
		add_row(row_load(1, 63'd0, 1'b1));
		add_row(row_bin(63'd1, 1'b0, 0, 0, 1'b0, 1'b1, 0, 1'b0));
		add_row(row_load(0, 63'd100, 1'b0));
		add_row(row_load(1, 63'd50, 1'b1));
		add_row(row_bin(63'd75, 1'b0, 0, 0, 1'b0, 1'b1, 0, 1'b0));
		add_row(row_load(1, 63'd200, 1'b0));
		add_row(row_load(2, 63'd300, 1'b0));
		add_row(row_load(3, 63'd300, 1'b1));
		add_row(row_load(3, 63'd400, 1'b0));
		add_row(row_reg(REG_EDGE_COUNT, 4));
		add_row(row_bin(63'd250, 1'b0, 0, 0, 1'b0, 1'b0, 0, 1'b0));
		add_row(row_bin(63'd400, 1'b1, 7, 7, 1'b0, 1'b0, 0, 1'b0));
		add_row(row_bin(63'd401, 1'b0, 0, 0, 1'b0, 1'b1, 0, 1'b0));
		// unordered table: 100, 200, 50, 400
		add_row(row_load(2, 63'd50, 1'b1));
		add_row(row_bin(63'd150, 1'b0, 0, 0, 1'b0, 1'b0, 0, 1'b0));
		add_row(row_reg(REG_EDGE_COUNT, 0));
		add_row(row_bin(63'd300, 1'b0, 0, 0, 1'b0, 1'b0, 0, 1'b0));
		add_row(row_reg(REG_SC_EN, 1));
		add_row(row_reg(REG_NUM_GROUPS, 4));
		add_row(row_reg(REG_OUT_MODE, 0));
		add_row(row_bin(TOP63[62:0], 1'b1, 0, 1, 1'b0, 1'b0, 0, 1'b0));
		add_row(row_bin(63'd0, 1'b1, 9, 3, 1'b1, 1'b1, 0, 1'b0));
		add_row(row_bin(63'd150, 1'b0, 9, 9, 1'b1, 1'b0, 0, 1'b0));
		add_row(row_reg(REG_OUT_MODE, 1));
		add_row(row_bin(63'd0, 1'b1, 0, 200, 1'b0, 1'b0, 0, 1'b0));
		add_row(row_reg(REG_NUM_GROUPS, 0));
		add_row(row_bin(63'd0, 1'b1, 0, 0, 1'b1, 1'b1, 0, 1'b0));
		add_row(row_reg(REG_NUM_GROUPS, 511));
		add_row(row_bin(63'd0, 1'b1, 255, 0, 1'b0, 1'b0, 0, 1'b0));
		add_row(row_bin(63'd0, 1'b1, 0, 255, 1'b0, 1'b0, 0, 1'b0));

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_REG) begin
				drain_bins();
				write_reg(plan[i].reg_sel, plan[i].reg_val);
			end else begin
				send_req(plan[i].req, plan[i].typed, plan[i].want);
			end
		end

		// Random phases: fresh settings, a table refill when needed or at random, then mixed traffic
		phase = 0;
		while (sent < ITEM_TARGET) begin
			case (phase)
				0: ec = 256;
				1: ec = 2;
				2: ec = 511;
				3: ec = 1;
				default:
					case ($urandom_range(9))
						0:       ec = 0;
						1:       ec = 300;
						2:       ec = 256;
						3, 4, 5: ec = $urandom_range(16, 2);
						default: ec = $urandom_range(256, 2);
					endcase
			endcase
			case ($urandom_range(7))
				0:       ngv = 0;
				1:       ngv = 1;
				2:       ngv = 256;
				3:       ngv = 511;
				default: ngv = $urandom_range(256, 1);
			endcase
			drain_bins();
			no_idle = (phase == 2);
			write_reg(REG_EDGE_COUNT, ec);
			write_reg(REG_SC_EN, $urandom_range(1));
			write_reg(REG_NUM_GROUPS, ngv);
			write_reg(REG_OUT_MODE, $urandom_range(1));
			n = edges_in_use();
			if (filled < n || $urandom_range(3) == 0)
				refill_edges(($urandom_range(2) == 0) ? $urandom_range(256, n) : n);
			repeat ($urandom_range(220, 120))
				if (sent < ITEM_TARGET) drive_mix_item();
			phase++;
		end

		drain_bins();
		no_idle = 1'b0;
		repeat (PIPE_DEPTH + 16) @(posedge clk);
		if (fails == 0 && pending_bins.size() == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule

`default_nettype wire
